/* hw/rtl/svsm_pkg.sv */
// Shared types and constants for the six-voice sample mixer.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps

package svsm_pkg;

  localparam int unsigned NUM_VOICES   = 6;
  localparam int unsigned NUM_CLIPS    = 9;
  localparam int unsigned POS_BITS     = 13;
  localparam int unsigned LEN_BITS     = 13;
  localparam int unsigned VOICE_BITS   = 3;
  localparam int unsigned CLIP_BITS    = 4;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned OPC_BITS     = 2;
  localparam int unsigned ADDR_IN_BITS = 12;
  localparam int unsigned DATA_IN_BITS = 16;
  localparam int unsigned OUT_BITS     = 16;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned CNT_BITS     = 3;
  localparam int unsigned STEP_BITS    = 3;
  localparam int unsigned MSEL_BITS    = 2;
  localparam int unsigned REM_BITS     = 3;

  typedef enum logic [OPC_BITS-1:0] {
    OP_TICK      = 2'd0,
    OP_TRIGGER   = 2'd1,
    OP_STOP_LOOP = 2'd2,
    OP_WRITE_MEM = 2'd3
  } op_e;

  localparam logic [VOICE_BITS-1:0] V_SHOT    = 3'd0;
  localparam logic [VOICE_BITS-1:0] V_MARCH   = 3'd1;
  localparam logic [VOICE_BITS-1:0] V_LOOP    = 3'd2;
  localparam logic [VOICE_BITS-1:0] V_BLAST_A = 3'd3;
  localparam logic [VOICE_BITS-1:0] V_BLAST_B = 3'd4;
  localparam logic [VOICE_BITS-1:0] V_BLAST_C = 3'd5;

  localparam logic [CLIP_BITS-1:0] CLIP_SHOT    = 4'd0;
  localparam logic [CLIP_BITS-1:0] CLIP_MARCH0  = 4'd1;
  localparam logic [CLIP_BITS-1:0] CLIP_LOOP    = 4'd5;
  localparam logic [CLIP_BITS-1:0] CLIP_BLAST_A = 4'd6;
  localparam logic [CLIP_BITS-1:0] CLIP_BLAST_B = 4'd7;
  localparam logic [CLIP_BITS-1:0] CLIP_BLAST_C = 4'd8;

  localparam logic [POS_BITS-1:0]  POS_IDLE       = '1;
  localparam logic [MSEL_BITS-1:0] MSEL_RESET     = '1;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [LEN_BITS-1:0] len_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ABS,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } state_e;

endpackage

/* hw/rtl/svsm_clip_mem.sv */
// Clip sample memory: one write port, one registered read port.
// No package dependencies; instantiated by six_voice_sample_mixer_unit.
`timescale 1ns / 1ps

module svsm_clip_mem #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned DATA_BITS = 16,
  parameter int unsigned DEPTH     = 36864
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  logic [DATA_BITS-1:0] wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] rd_addr_i,
  output logic [DATA_BITS-1:0] rd_data_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* hw/rtl/six_voice_sample_mixer_unit.sv */
// Six-voice sample mixer: top level with voice sequencer and shared adder.
// Depends on svsm_pkg and svsm_clip_mem.
`timescale 1ns / 1ps

// Plays six sample voices from one clip memory of nine regions. Trigger, stop
// and memory-write beats leave the input ready for the next beat. A tick beat
// holds off the next beat until it is done: the voices are walked through the
// single memory read port, then one adder does the magnitude, a bit-serial
// restoring divide by the voice count (SAMPLE_BITS + 3 steps) and the sign
// fix. A tick with no voice playing skips the divide and the sign fix. The
// result sits in an output register, so a new beat is taken while it waits;
// a second tick result holds the input off until the first one has been
// taken. Length registers are written on the cfg port, which is always ready.
module six_voice_sample_mixer_unit #(
  parameter int unsigned CLIP_ADDR_BITS = 12,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [svsm_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [svsm_pkg::LEN_BITS-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [svsm_pkg::OPC_BITS-1:0]        opcode_i,
  input  logic [svsm_pkg::VOICE_BITS-1:0]      voice_i,
  input  logic [svsm_pkg::CLIP_BITS-1:0]       clip_i,
  input  logic [svsm_pkg::ADDR_IN_BITS-1:0]    address_i,
  input  logic signed [svsm_pkg::DATA_IN_BITS-1:0] sample_data_i,
  input  logic                                 game_over_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [svsm_pkg::OUT_BITS-1:0] mixed_sample_o,
  output logic [svsm_pkg::WORD_BITS-1:0]       stereo_word_o,
  output logic [svsm_pkg::CNT_BITS-1:0]        active_count_o
);

  import svsm_pkg::*;

  localparam int unsigned MEM_ADDR_BITS = CLIP_ADDR_BITS + CLIP_BITS;
  localparam int unsigned MEM_DEPTH     = NUM_CLIPS * (2 ** CLIP_ADDR_BITS);
  localparam int unsigned ACC_BITS      = SAMPLE_BITS + 3;
  localparam int unsigned BIT_CNT_BITS  = $clog2(ACC_BITS);

  state_e state_q, state_d;
  pos_t   pos_q [NUM_VOICES];
  pos_t   pos_d [NUM_VOICES];
  len_t   len_q [NUM_VOICES];
  logic   loop_en_q, loop_en_d;
  logic [MSEL_BITS-1:0] msel_q, msel_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic   play_q, play_d;
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [REM_BITS-1:0] rem_q, rem_d;
  logic   neg_q, neg_d;
  logic [BIT_CNT_BITS-1:0] bit_q, bit_d;
  logic   go_q, go_d;

  logic out_valid_q, out_valid_d;
  logic signed [OUT_BITS-1:0] mixed_q, mixed_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [CNT_BITS-1:0] count_q, count_d;

  logic in_accept, out_free, out_load;
  op_e  op;

  // shared adder
  logic [ACC_BITS-1:0] add_a, add_b, add_y;
  logic add_ci;

  // current voice in the read walk
  logic in_walk;
  pos_t cur_pos, pos_inc, loop_next;
  len_t cur_len;
  logic cur_play;
  logic [CLIP_BITS-1:0] cur_clip;

  logic mem_wr_en, mem_rd_en;
  logic [MEM_ADDR_BITS-1:0] mem_wr_addr, mem_rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic signed [OUT_BITS-1:0] avg16;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign op          = op_e'(opcode_i);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ST_DONE) && out_free;

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;
  assign stereo_word_o  = word_q;
  assign active_count_o = count_q;

  assign add_y = add_a + add_b + ACC_BITS'(add_ci);

  // voice walk
  assign in_walk   = (state_q == ST_READ) && (step_q < STEP_BITS'(NUM_VOICES));
  assign cur_pos   = pos_q[step_q];
  assign cur_len   = len_q[step_q];
  assign pos_inc   = cur_pos + 1'b1;
  assign loop_next = (pos_inc >= cur_len) ? '0 : pos_inc;
  assign cur_play  = (step_q == V_LOOP) ? loop_en_q : (cur_pos < cur_len);

  always_comb begin
    case (step_q)
      V_SHOT:    cur_clip = CLIP_SHOT;
      V_MARCH:   cur_clip = CLIP_MARCH0 + CLIP_BITS'(msel_q);
      V_LOOP:    cur_clip = CLIP_LOOP;
      V_BLAST_A: cur_clip = CLIP_BLAST_A;
      V_BLAST_B: cur_clip = CLIP_BLAST_B;
      V_BLAST_C: cur_clip = CLIP_BLAST_C;
      default:   cur_clip = CLIP_SHOT;
    endcase
  end

  assign mem_rd_en   = in_walk && cur_play;
  assign mem_rd_addr = {cur_clip, CLIP_ADDR_BITS'(cur_pos)};
  assign mem_wr_en   = in_accept && (op == OP_WRITE_MEM) &&
                       (clip_i < CLIP_BITS'(NUM_CLIPS));
  assign mem_wr_addr = {clip_i, CLIP_ADDR_BITS'(address_i)};
  assign wr_data     = SAMPLE_BITS'(sample_data_i);

  svsm_clip_mem #(
    .ADDR_BITS (MEM_ADDR_BITS),
    .DATA_BITS (SAMPLE_BITS),
    .DEPTH     (MEM_DEPTH)
  ) u_clip_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (rd_data)
  );

  assign avg16 = OUT_BITS'(acc_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (op == OP_TICK)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (step_q == STEP_BITS'(NUM_VOICES)) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        state_d = (cnt_q == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (bit_q == '0) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and adder operands
  always_comb begin
    pos_d     = pos_q;
    loop_en_d = loop_en_q;
    msel_d    = msel_q;
    step_d    = step_q;
    play_d    = play_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    bit_d     = bit_q;
    go_d      = go_q;
    add_a     = '0;
    add_b     = '0;
    add_ci    = 1'b0;
    mixed_d   = mixed_q;
    word_d    = word_q;
    count_d   = count_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (op)
            OP_TICK: begin
              go_d   = game_over_i;
              step_d = '0;
              play_d = 1'b0;
              acc_d  = '0;
              cnt_d  = '0;
            end
            OP_TRIGGER: begin
              if (voice_i == V_LOOP) begin
                if (!game_over_i) begin
                  loop_en_d = 1'b1;
                end
              end else if (voice_i < VOICE_BITS'(NUM_VOICES)) begin
                pos_d[voice_i] = '0;
                if (voice_i == V_MARCH) begin
                  msel_d = msel_q + 1'b1;
                end
              end
            end
            OP_STOP_LOOP: begin
              loop_en_d     = 1'b0;
              pos_d[V_LOOP] = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // add the sample read for the previous voice
        add_a = acc_q;
        add_b = ACC_BITS'(rd_data);
        if (play_q) begin
          acc_d = add_y;
        end
        if (in_walk) begin
          play_d = cur_play;
          if (cur_play) begin
            cnt_d = cnt_q + 1'b1;
            pos_d[step_q] = (step_q == V_LOOP) ? loop_next : pos_inc;
          end
        end
        step_d = step_q + 1'b1;
      end
      ST_ABS: begin
        add_a  = '0;
        add_b  = ~acc_q;
        add_ci = 1'b1;
        rem_d  = '0;
        bit_d  = BIT_CNT_BITS'(ACC_BITS - 1);
        if (cnt_q == '0) begin
          acc_d = '0;
          neg_d = 1'b0;
        end else begin
          neg_d = acc_q[ACC_BITS-1];
          if (acc_q[ACC_BITS-1]) begin
            acc_d = add_y;
          end
        end
      end
      ST_DIV: begin
        // restoring step: acc shifts out dividend bits, shifts in quotient bits
        add_a  = ACC_BITS'({rem_q, acc_q[ACC_BITS-1]});
        add_b  = ~ACC_BITS'(cnt_q);
        add_ci = 1'b1;
        if (!add_y[ACC_BITS-1]) begin
          rem_d = add_y[REM_BITS-1:0];
          acc_d = {acc_q[ACC_BITS-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[REM_BITS-2:0], acc_q[ACC_BITS-1]};
          acc_d = {acc_q[ACC_BITS-2:0], 1'b0};
        end
        bit_d = bit_q - 1'b1;
      end
      ST_SIGN: begin
        add_a  = '0;
        add_b  = ~acc_q;
        add_ci = 1'b1;
        if (neg_q) begin
          acc_d = add_y;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          mixed_d = avg16;
          word_d  = go_q ? '0 : {avg16, avg16};
          count_d = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loop_en_q   <= 1'b0;
      msel_q      <= MSEL_RESET;
      step_q      <= '0;
      play_q      <= 1'b0;
      cnt_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      // one-shot voices start idle, the loop voice at its first sample
      for (int i = 0; i < NUM_VOICES; i++) begin
        pos_q[i] <= (i == int'(V_LOOP)) ? '0 : POS_IDLE;
        len_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      loop_en_q   <= loop_en_d;
      msel_q      <= msel_d;
      step_q      <= step_d;
      play_q      <= play_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      if (cfg_valid_i && (cfg_index_i < CFG_IDX_BITS'(NUM_VOICES))) begin
        len_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    go_q    <= go_d;
    mixed_q <= mixed_d;
    word_q  <= word_d;
    count_q <= count_d;
  end

endmodule

/* tb/tb_six_voice_sample_mixer_unit.sv */
// Self-checking testbench for six_voice_sample_mixer_unit: directed voice cases, then random
// traffic over several length settings, with burst/gap input and a stalling output side.
// Depends on svsm_pkg and the mixer RTL only.
`timescale 1ns / 1ps

module tb_six_voice_sample_mixer_unit;
  import svsm_pkg::*;

  localparam int unsigned CLIP_ADDR_BITS = 12;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned CLIP_WORDS     = 1 << CLIP_ADDR_BITS;
  localparam int unsigned MEM_WORDS      = NUM_CLIPS * CLIP_WORDS;
  localparam int unsigned CFG_REGS       = 1 << CFG_IDX_BITS;
  localparam int unsigned DRAIN_CYCLES   = 40;     // covers a whole tick at 16-bit samples
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned RANDOM_ITEMS   = 600;    // beats, fills included
  localparam int unsigned RANDOM_PHASES  = 6;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_SHOT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_MARCH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_LOOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_BLAST_A = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_BLAST_B = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_BLAST_C = 3'd5;

  localparam len_t LEN_MAX = 13'd4096;
  localparam logic signed [DATA_IN_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [DATA_IN_BITS-1:0] SAMPLE_MAX = 16'sh7fff;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC, RDY_BURSTY} ready_mode_e;

  typedef struct {
    op_e                             op;
    logic [VOICE_BITS-1:0]           voice;
    logic [CLIP_BITS-1:0]            clip;
    logic [ADDR_IN_BITS-1:0]         addr;
    logic signed [DATA_IN_BITS-1:0]  data;
    logic                            game_over;
  } mix_cmd_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] mix;
    logic [WORD_BITS-1:0]       word;
    logic [CNT_BITS-1:0]        cnt;
  } mix_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]          cfg_index_i;
  logic [LEN_BITS-1:0]              cfg_data_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [OPC_BITS-1:0]              opcode_i;
  logic [VOICE_BITS-1:0]            voice_i;
  logic [CLIP_BITS-1:0]             clip_i;
  logic [ADDR_IN_BITS-1:0]          address_i;
  logic signed [DATA_IN_BITS-1:0]   sample_data_i;
  logic                             game_over_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic signed [OUT_BITS-1:0]       mixed_sample_o;
  logic [WORD_BITS-1:0]             stereo_word_o;
  logic [CNT_BITS-1:0]              active_count_o;

  six_voice_sample_mixer_unit #(
    .CLIP_ADDR_BITS(CLIP_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .voice_i       (voice_i),
    .clip_i        (clip_i),
    .address_i     (address_i),
    .sample_data_i (sample_data_i),
    .game_over_i   (game_over_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mixed_sample_o(mixed_sample_o),
    .stereo_word_o (stereo_word_o),
    .active_count_o(active_count_o)
  );

  // mixer shadow state
  pos_t                            voice_pos [NUM_VOICES];
  len_t                            voice_len [NUM_VOICES];
  logic                            loop_on;
  logic [MSEL_BITS-1:0]            march_sel;
  logic signed [DATA_IN_BITS-1:0]  clip_mem [MEM_WORDS];
  bit                              clip_written [MEM_WORDS];
  mix_result_t                     expected_mix [$];

  int errors = 0;
  int beats_sent = 0;
  bit steady_send = 1'b0;
  bit hold_req = 1'b0;
  int burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_six_voice_sample_mixer_unit: done, errors");
    $finish;
  end

  function automatic void reset_mixer_model();
    int i;
    for (i = 0; i < NUM_VOICES; i++) begin
      voice_pos[i] = POS_IDLE;
      voice_len[i] = '0;
    end
    voice_pos[V_LOOP] = '0;
    loop_on = 1'b0;
    march_sel = MSEL_RESET;
    for (i = 0; i < MEM_WORDS; i++) clip_written[i] = 1'b0;
  endfunction

  // Returns whether voice v plays on the next tick, and which memory word it reads.
  function automatic bit voice_source(input int v, output int mem_idx);
    int clip_idx;
    case (v)
      V_SHOT:    clip_idx = CLIP_SHOT;
      V_MARCH:   clip_idx = CLIP_MARCH0 + march_sel;
      V_LOOP:    clip_idx = CLIP_LOOP;
      V_BLAST_A: clip_idx = CLIP_BLAST_A;
      V_BLAST_B: clip_idx = CLIP_BLAST_B;
      default:   clip_idx = CLIP_BLAST_C;
    endcase
    mem_idx = clip_idx * CLIP_WORDS + int'(voice_pos[v] % CLIP_WORDS);
    return (v == V_LOOP) ? loop_on : (voice_pos[v] < voice_len[v]);
  endfunction

  function automatic void apply_beat(input mix_cmd_t c);
    int v, idx, sum, count, avg;
    logic [OUT_BITS-1:0] half;
    mix_result_t r;
    case (c.op)
      OP_WRITE_MEM: begin
        if (c.clip < NUM_CLIPS) begin
          idx = int'(c.clip) * CLIP_WORDS + int'(c.addr);
          clip_mem[idx] = c.data;
          clip_written[idx] = 1'b1;
        end
      end
      OP_STOP_LOOP: begin
        loop_on = 1'b0;
        voice_pos[V_LOOP] = '0;
      end
      OP_TRIGGER: begin
        if (c.voice == V_LOOP) begin
          if (!c.game_over) loop_on = 1'b1;
        end else if (c.voice < NUM_VOICES) begin
          voice_pos[c.voice] = '0;
          if (c.voice == V_MARCH) march_sel = march_sel + 1'b1;
        end
      end
      default: begin
        sum = 0;
        count = 0;
        for (v = 0; v < NUM_VOICES; v++) begin
          if (voice_source(v, idx)) begin
            sum += clip_mem[idx];
            count++;
            voice_pos[v] = voice_pos[v] + 1'b1;
            if (v == V_LOOP && voice_pos[v] >= voice_len[V_LOOP]) voice_pos[v] = '0;
          end
        end
        avg = (count == 0) ? 0 : sum / count;
        half = avg[OUT_BITS-1:0];
        r.mix = half;
        r.word = c.game_over ? '0 : {half, half};
        r.cnt = count[CNT_BITS-1:0];
        expected_mix.push_back(r);
      end
    endcase
  endfunction

  function automatic mix_cmd_t random_cmd(input op_e op);
    mix_cmd_t c;
    c.op = op;
    c.voice = VOICE_BITS'($urandom);
    c.clip = CLIP_BITS'($urandom);
    c.addr = ADDR_IN_BITS'($urandom);
    c.data = DATA_IN_BITS'($urandom);
    c.game_over = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  // Offers one beat, waits for the handshake, then, unless sending steadily, idles per the burst pattern.
  task automatic send_beat(input mix_cmd_t c);
    int gap;
    in_valid_i    <= 1'b1;
    opcode_i      <= c.op;
    voice_i       <= c.voice;
    clip_i        <= c.clip;
    address_i     <= c.addr;
    sample_data_i <= c.data;
    game_over_i   <= c.game_over;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    apply_beat(c);
    beats_sent++;
    if (!steady_send) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(0, 11);
      end
    end
  endtask

  task automatic trigger_voice(input logic [VOICE_BITS-1:0] v, input logic go);
    mix_cmd_t c;
    c = random_cmd(OP_TRIGGER);
    c.voice = v;
    c.game_over = go;
    send_beat(c);
  endtask

  task automatic write_sample(input logic [CLIP_BITS-1:0] clip,
                              input logic [ADDR_IN_BITS-1:0] addr,
                              input logic signed [DATA_IN_BITS-1:0] data);
    mix_cmd_t c;
    c = random_cmd(OP_WRITE_MEM);
    c.clip = clip;
    c.addr = addr;
    c.data = data;
    send_beat(c);
  endtask

  task automatic stop_loop();
    send_beat(random_cmd(OP_STOP_LOOP));
  endtask

  // Fills any clip word the tick would read that was never written, then sends the tick.
  task automatic play_tick(input logic go);
    mix_cmd_t c;
    int v, idx;
    for (v = 0; v < NUM_VOICES; v++) begin
      if (voice_source(v, idx) && !clip_written[idx])
        write_sample(CLIP_BITS'(idx / CLIP_WORDS), ADDR_IN_BITS'(idx % CLIP_WORDS),
                     DATA_IN_BITS'($urandom));
    end
    c = random_cmd(OP_TICK);
    c.game_over = go;
    send_beat(c);
  endtask

  task automatic write_len(input logic [CFG_IDX_BITS-1:0] idx, input len_t val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_VOICES) voice_len[idx] = val;
  endtask

  // Sender goes quiet until every pending result is in, then lets the block settle.
  task automatic wait_drain();
    int n;
    in_valid_i <= 1'b0;
    n = 0;
    while (expected_mix.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (expected_mix.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_mix.size());
      errors += expected_mix.size();
      expected_mix.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic len_t pick_len(input int phase);
    int r;
    if (phase == 0) return LEN_MAX;
    if (phase == 1) return '0;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LEN_MAX;
    if (r == 2) return len_t'($urandom_range(1, LEN_MAX));
    return len_t'($urandom_range(1, 24));
  endfunction

  task automatic test_idle_after_reset();
    play_tick(1'b0);
    play_tick(1'b1);
    // zero length: a triggered voice stays silent
    trigger_voice(V_SHOT, 1'b0);
    play_tick(1'b0);
  endtask

  task automatic test_extreme_samples();
    int i;
    wait_drain();
    write_len(REG_LEN_SHOT, 13'd1);
    write_len(REG_LEN_MARCH, 13'd1);
    write_len(REG_LEN_LOOP, 13'd0);
    write_len(REG_LEN_BLAST_A, 13'd1);
    write_len(REG_LEN_BLAST_B, 13'd1);
    write_len(REG_LEN_BLAST_C, 13'd1);
    for (i = NUM_VOICES; i < CFG_REGS; i++) write_len(i[CFG_IDX_BITS-1:0], len_t'($urandom));
    write_sample(CLIP_SHOT, '0, SAMPLE_MIN);
    write_sample(CLIP_MARCH0, '0, SAMPLE_MIN);
    write_sample(CLIP_LOOP, '0, SAMPLE_MIN);
    write_sample(CLIP_BLAST_A, '0, SAMPLE_MIN);
    write_sample(CLIP_BLAST_B, '0, SAMPLE_MIN);
    write_sample(CLIP_BLAST_C, '0, SAMPLE_MIN);
    write_sample('1, '1, SAMPLE_MAX);           // region past the last clip
    write_sample(CLIP_BLAST_C, '1, SAMPLE_MAX);
    trigger_voice('1, 1'b0);                    // no such voice
    trigger_voice(V_LOOP, 1'b1);                // refused during game over
    for (i = 0; i < NUM_VOICES; i++) trigger_voice(i[VOICE_BITS-1:0], 1'b0);
    play_tick(1'b1);
    write_sample(CLIP_LOOP, '0, SAMPLE_MAX);
    play_tick(1'b0);                            // loop alone, zero length replays word 0
    stop_loop();
    play_tick(1'b0);
  endtask

  task automatic test_loop_wrap_and_march();
    wait_drain();
    write_len(REG_LEN_LOOP, 13'd3);
    write_len(REG_LEN_MARCH, 13'd2);
    trigger_voice(V_MARCH, 1'b0);
    trigger_voice(V_LOOP, 1'b0);
    repeat (4) play_tick($urandom_range(0, 1) == 1);
    trigger_voice(V_MARCH, 1'b0);
    play_tick(1'b0);
    trigger_voice(V_MARCH, 1'b0);               // retrigger mid-clip
    play_tick(1'b0);
    stop_loop();
    play_tick(1'b0);
  endtask

  task automatic test_random_traffic();
    int phase, stop_at, r, i;
    mix_cmd_t c;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drain();
      for (i = 0; i < NUM_VOICES; i++) write_len(i[CFG_IDX_BITS-1:0], pick_len(phase));
      if ($urandom_range(0, 2) == 0)
        write_len(CFG_IDX_BITS'($urandom_range(NUM_VOICES, CFG_REGS - 1)), len_t'($urandom));
      steady_send = (phase == 2);
      stop_at = beats_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (beats_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          play_tick($urandom_range(0, 4) == 0);
        end else if (r < 70) begin
          trigger_voice(VOICE_BITS'($urandom_range(0, NUM_VOICES - 1)),
                        $urandom_range(0, 3) == 0);
        end else if (r < 75) begin
          stop_loop();
        end else if (r < 93) begin
          c = random_cmd(OP_WRITE_MEM);
          c.clip = CLIP_BITS'($urandom_range(0, NUM_CLIPS - 1));
          if ($urandom_range(0, 3) != 0) c.addr = ADDR_IN_BITS'($urandom_range(0, 63));
          send_beat(c);
        end else if (r < 96) begin
          trigger_voice(VOICE_BITS'($urandom_range(NUM_VOICES, 7)), $urandom_range(0, 1) == 1);
        end else begin
          write_sample(CLIP_BITS'($urandom_range(NUM_CLIPS, 15)), ADDR_IN_BITS'($urandom),
                       DATA_IN_BITS'($urandom));
        end
      end
      steady_send = 1'b0;
    end
  endtask

  // Output side holds off while ticks keep coming, so the block has to stall its input.
  task automatic test_backpressure();
    int i;
    wait_drain();
    for (i = 0; i < NUM_VOICES; i++) trigger_voice(i[VOICE_BITS-1:0], 1'b0);
    hold_req = 1'b1;
    steady_send = 1'b1;
    repeat (24) play_tick($urandom_range(0, 3) == 0);
    steady_send = 1'b0;
    wait_drain();
  endtask

  initial begin : receiver
    ready_mode_e mode;
    int left, cyc;
    out_ready_i <= 1'b0;
    mode = RDY_ALWAYS;
    left = 0;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = ready_mode_e'($urandom_range(0, 4));
          left = $urandom_range(40, 300);
        end
        left--;
        case (mode)
          RDY_ALWAYS:   out_ready_i <= 1'b1;
          RDY_COIN:     out_ready_i <= ($urandom_range(0, 1) == 1);
          RDY_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
          RDY_PERIODIC: out_ready_i <= (cyc % 7) != 0;
          default:      out_ready_i <= (cyc % 64) < 48;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    mix_result_t want;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_mix.size() == 0) begin
        $display("%0t: result beat with none expected: mixed_sample %0d", $time, mixed_sample_o);
        errors++;
      end else begin
        want = expected_mix.pop_front();
        if (mixed_sample_o !== want.mix) begin
          $display("%0t: mixed_sample expected %0d got %0d", $time, want.mix, mixed_sample_o);
          errors++;
        end
        if (stereo_word_o !== want.word) begin
          $display("%0t: stereo_word expected %h got %h", $time, want.word, stereo_word_o);
          errors++;
        end
        if (active_count_o !== want.cnt) begin
          $display("%0t: active_count expected %0d got %0d", $time, want.cnt, active_count_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    opcode_i      <= OP_TICK;
    voice_i       <= '0;
    clip_i        <= '0;
    address_i     <= '0;
    sample_data_i <= '0;
    game_over_i   <= 1'b0;
    reset_mixer_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_after_reset();
    test_extreme_samples();
    test_loop_wrap_and_march();
    test_random_traffic();
    test_backpressure();
    wait_drain();
    if (errors == 0) begin
      $display("tb_six_voice_sample_mixer_unit: done, clean");
    end else begin
      $display("tb_six_voice_sample_mixer_unit: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/svsm_pkg.sv
hw/rtl/svsm_clip_mem.sv
hw/rtl/six_voice_sample_mixer_unit.sv
tb/tb_six_voice_sample_mixer_unit.sv
